### rtl/core/packet_key_nonce_derivation_defines.svh
// Assertion macros for the packet key and nonce derivation checker.
// Depends on nothing.
`ifndef PACKET_KEY_NONCE_DERIVATION_DEFINES_SVH
`define PACKET_KEY_NONCE_DERIVATION_DEFINES_SVH

// implication checked on the next edge, disabled in reset
`define PKND_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication checked on the next edge, live during reset too
`define PKND_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pknd_pkg.sv
// Shared types, constants and SHA-256 helpers for packet key and nonce derivation.
// No dependencies.
package pknd_pkg;

   localparam int unsigned DIV_DIGITS   = 4;
   localparam int unsigned DIV_STAGES   = 2 * DIV_DIGITS;
   localparam int unsigned DIV_SHIFT    = 42;
   localparam logic [12:0] DIV_SPAN_ODD = 13'd5625;        // 45000 >> 3
   localparam logic [29:0] DIV_RECIP    = 30'd781874936;   // ceil(2^42 / 5625)
   localparam int unsigned SHA_ROUNDS   = 64;
   localparam logic [15:0] WINDOW_SPAN  = 16'd45000;
   localparam logic [15:0] ROT_FACTOR   = 16'hAF6E;
   localparam logic [63:0] BLOCK_BYTES  = 64'd16;

   typedef enum logic [2:0] {
      CSR_KEY_LOW  = 3'd0,
      CSR_KEY_HIGH = 3'd1,
      CSR_IV_LOW   = 3'd2,
      CSR_IV_HIGH  = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic        valid;
      logic        base;
      logic [63:0] pos;
   } pknd_ctl_type;

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_H0 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] PAD_WORD = 32'h80000000;
   localparam logic [31:0] LEN_WORD = 32'h00000100;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] bswap(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

### rtl/core/pknd_div.sv
// Window divide (position / 45000), rotation multiply and IV add pipeline.
// Depends on pknd_pkg.
module pknd_div
   import pknd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pknd_ctl_type  ctl_in,
   input  logic [127:0]  iv,
   output pknd_ctl_type  ctl_out,
   output logic [127:0]  rot_out
);

   pknd_ctl_type ctl_pipe [DIV_STAGES+1];
   logic [12:0]  rem_pipe [DIV_DIGITS+1];
   logic [63:0]  quo_pipe [DIV_DIGITS+1];

   assign ctl_pipe[0] = ctl_in;
   assign rem_pipe[0] = '0;
   assign quo_pipe[0] = '0;

   // pos / 45000 = (pos >> 3) / 5625, long division in 16-bit digits;
   // per digit: reciprocal multiply, then remainder
   for (genvar k = 0; k < DIV_DIGITS; k++) begin : g_div
      logic [63:0]  num;
      logic [28:0]  part_in, part_ff;
      logic [58:0]  prod;
      logic [15:0]  qd_in, qd_ff;
      logic [63:0]  quo_a_ff;
      pknd_ctl_type ctl_a_ff, ctl_b_ff;
      logic [12:0]  rem_in, rem_ff;
      logic [63:0]  quo_in, quo_ff;

      always_comb begin
         num     = {3'b000, ctl_pipe[2*k].pos[63:3]};
         part_in = {rem_pipe[k], num[16*(DIV_DIGITS-1-k) +: 16]};
         prod    = 59'(part_in) * 59'(DIV_RECIP);
         qd_in   = prod[DIV_SHIFT +: 16];
      end

      always_comb begin
         rem_in = 13'(part_ff - 29'(qd_ff) * 29'(DIV_SPAN_ODD));
         quo_in = {quo_a_ff[47:0], qd_ff};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_a_ff <= '0;
            ctl_b_ff <= '0;
         end else begin
            ctl_a_ff <= ctl_pipe[2*k];
            ctl_b_ff <= ctl_a_ff;
         end
         part_ff  <= part_in;
         qd_ff    <= qd_in;
         quo_a_ff <= quo_pipe[k];
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
      end

      assign ctl_pipe[2*k+1] = ctl_a_ff;
      assign ctl_pipe[2*k+2] = ctl_b_ff;
      assign rem_pipe[k+1]   = rem_ff;
      assign quo_pipe[k+1]   = quo_ff;
   end

   pknd_ctl_type mul_ctl_ff, sum_ctl_ff, rot_ctl_ff;
   logic [47:0]  prod_lo_ff, prod_hi_ff;
   logic [63:0]  prod_ff;
   logic [127:0] rot_ff;
   logic [47:0]  prod_lo_in, prod_hi_in;
   logic [63:0]  prod_in;
   logic [127:0] rot_in;

   always_comb begin
      prod_lo_in = quo_pipe[DIV_DIGITS][31:0] * ROT_FACTOR;
      prod_hi_in = quo_pipe[DIV_DIGITS][63:32] * ROT_FACTOR;
      prod_in    = {16'b0, prod_lo_ff} + {prod_hi_ff[31:0], 32'b0};
      rot_in     = iv + {64'b0, prod_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff <= '0;
         sum_ctl_ff <= '0;
         rot_ctl_ff <= '0;
      end else begin
         mul_ctl_ff <= ctl_pipe[DIV_STAGES];
         sum_ctl_ff <= mul_ctl_ff;
         rot_ctl_ff <= sum_ctl_ff;
      end
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      prod_ff    <= prod_in;
      rot_ff     <= rot_in;
   end

   assign ctl_out = rot_ctl_ff;
   assign rot_out = rot_ff;

endmodule

### rtl/core/pknd_sha.sv
// One-block SHA-256 pipeline, one round per stage, with the 128-bit digest fold.
// Depends on pknd_pkg.
module pknd_sha
   import pknd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  pknd_ctl_type  ctl_in,
   input  logic [127:0]  rot,
   input  logic [127:0]  base_key,
   input  logic [127:0]  cipher_key,
   input  logic [127:0]  iv,
   output pknd_ctl_type  ctl_out,
   output logic [127:0]  fold_out
);

   pknd_ctl_type ctl_pipe [SHA_ROUNDS+1];
   logic [255:0] st_pipe  [SHA_ROUNDS+1];
   logic [511:0] w_pipe   [SHA_ROUNDS+1];

   // message load: a || b, padded, word 0 in the low bits of the window
   logic [127:0] msg_a, msg_b;
   logic [511:0] w_load;
   logic [255:0] st_load;

   always_comb begin
      msg_a   = ctl_in.base ? cipher_key : base_key;
      msg_b   = ctl_in.base ? iv : rot;
      w_load  = '0;
      for (int j = 0; j < 4; j++) begin
         w_load[32*j +: 32]     = bswap(msg_a[32*j +: 32]);
         w_load[32*(j+4) +: 32] = bswap(msg_b[32*j +: 32]);
      end
      w_load[32*8 +: 32]  = PAD_WORD;
      w_load[32*15 +: 32] = LEN_WORD;
      for (int j = 0; j < 8; j++) begin
         st_load[32*(7-j) +: 32] = SHA_H0[j];
      end
   end

   pknd_ctl_type ld_ctl_ff;
   logic [255:0] ld_st_ff;
   logic [511:0] ld_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_ctl_ff <= '0;
      end else begin
         ld_ctl_ff <= ctl_in;
      end
      ld_st_ff <= st_load;
      ld_w_ff  <= w_load;
   end

   assign ctl_pipe[0] = ld_ctl_ff;
   assign st_pipe[0]  = ld_st_ff;
   assign w_pipe[0]   = ld_w_ff;

   for (genvar r = 0; r < SHA_ROUNDS; r++) begin : g_round
      logic [255:0] st_in;
      logic [511:0] w_in;

      always_comb begin
         logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wn;
         logic [511:0] wv;
         wv = w_pipe[r];
         a = st_pipe[r][255:224];
         b = st_pipe[r][223:192];
         c = st_pipe[r][191:160];
         d = st_pipe[r][159:128];
         e = st_pipe[r][127:96];
         f = st_pipe[r][95:64];
         g = st_pipe[r][63:32];
         h = st_pipe[r][31:0];
         t1 = h + bsig1(e) + ((e & f) ^ (~e & g)) + SHA_K[r] + wv[31:0];
         t2 = bsig0(a) + ((a & b) ^ (a & c) ^ (b & c));
         wn = ssig1(wv[32*14 +: 32]) + wv[32*9 +: 32] + ssig0(wv[32*1 +: 32]) + wv[31:0];
         st_in = {t1 + t2, a, b, c, d + t1, e, f, g};
         w_in  = {wn, wv[511:32]};
      end

      pknd_ctl_type ctl_ff;
      logic [255:0] st_ff;
      logic [511:0] w_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff <= '0;
         end else begin
            ctl_ff <= ctl_pipe[r];
         end
         st_ff <= st_in;
         w_ff  <= w_in;
      end

      assign ctl_pipe[r+1] = ctl_ff;
      assign st_pipe[r+1]  = st_ff;
      assign w_pipe[r+1]   = w_ff;
   end

   // digest, then first half XOR second half, bytes back to little-endian
   pknd_ctl_type dg_ctl_ff;
   logic [127:0] dg_ff;
   logic [127:0] dg_in;

   always_comb begin
      logic [31:0] hv [8];
      for (int j = 0; j < 8; j++) begin
         hv[j] = SHA_H0[j] + st_pipe[SHA_ROUNDS][32*(7-j) +: 32];
      end
      for (int j = 0; j < 4; j++) begin
         dg_in[32*j +: 32] = bswap(hv[j] ^ hv[j+4]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dg_ctl_ff <= '0;
      end else begin
         dg_ctl_ff <= ctl_pipe[SHA_ROUNDS];
      end
      dg_ff <= dg_in;
   end

   assign ctl_out  = dg_ctl_ff;
   assign fold_out = dg_ff;

endmodule

### rtl/core/packet_key_nonce_derivation.sv
// Packet key and nonce derivation top level: registers, base key control, output stage.
// Depends on pknd_pkg, pknd_div and pknd_sha.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+------------------------------
//  request  | req_start, req_key_pos | taken when req_start & !busy
//  response | rsp_strobe, rsp_*      | one cycle, no back-pressure
//  csr      | csr_valid/ready/index  | taken when csr_valid & csr_ready
//
// One word per cycle while busy is low; a request runs through the
// 11-stage divide/rotate pipe, the 66-stage SHA-256 pipe and the output stage.
// After reset and after any csr write, busy stays high while
// the base key runs through the same pipe. The receiver cannot stall.
module packet_key_nonce_derivation
   import pknd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        busy,
   input  logic [63:0] req_key_pos,
   output logic        rsp_strobe,
   output logic [63:0] rsp_gmac_key_low,
   output logic [63:0] rsp_gmac_key_high,
   output logic [63:0] rsp_gmac_nonce_low,
   output logic [63:0] rsp_gmac_nonce_high,
   output logic [63:0] rsp_ctr_nonce_low,
   output logic [63:0] rsp_ctr_nonce_high,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [127:0] key_ff, iv_ff, base_key_ff;
   logic         stale_ff, stale_in, inflight_ff, inflight_in;
   logic         csr_fire, inject, accept;
   pknd_ctl_type entry_ctl, div_ctl, sha_ctl;
   logic [127:0] rot, fold;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;
   assign busy      = stale_ff | inflight_ff;
   assign accept    = req_start & ~busy;
   assign inject    = stale_ff & ~inflight_ff;

   always_comb begin
      entry_ctl.valid = accept | inject;
      entry_ctl.base  = inject;
      entry_ctl.pos   = req_key_pos;
      stale_in        = csr_fire | (stale_ff & ~inject);
      inflight_in     = inject | (inflight_ff & ~(sha_ctl.valid & sha_ctl.base));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff      <= '0;
         iv_ff       <= '0;
         stale_ff    <= 1'b1;
         inflight_ff <= 1'b0;
      end else begin
         stale_ff    <= stale_in;
         inflight_ff <= inflight_in;
         if (csr_fire) begin
            case (csr_index_type'(csr_index))
               CSR_KEY_LOW:  key_ff[63:0]   <= csr_wdata;
               CSR_KEY_HIGH: key_ff[127:64] <= csr_wdata;
               CSR_IV_LOW:   iv_ff[63:0]    <= csr_wdata;
               CSR_IV_HIGH:  iv_ff[127:64]  <= csr_wdata;
               default: ;
            endcase
         end
      end
      // a result from before the latest csr write is dropped
      if (sha_ctl.valid & sha_ctl.base & ~stale_ff) begin
         base_key_ff <= fold;
      end
   end

   pknd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (entry_ctl),
      .iv      (iv_ff),
      .ctl_out (div_ctl),
      .rot_out (rot)
   );

   pknd_sha u_sha (
      .clock      (clock),
      .reset      (reset),
      .ctl_in     (div_ctl),
      .rot        (rot),
      .base_key   (base_key_ff),
      .cipher_key (key_ff),
      .iv         (iv_ff),
      .ctl_out    (sha_ctl),
      .fold_out   (fold)
   );

   logic         rsp_strobe_ff;
   logic [127:0] gkey_ff, gnonce_ff, cnonce_ff;
   logic [127:0] gkey_in, gnonce_in, cnonce_in;
   logic [63:0]  ctr_pos;

   always_comb begin
      ctr_pos   = sha_ctl.pos + BLOCK_BYTES;
      gkey_in   = (sha_ctl.pos < {48'b0, WINDOW_SPAN}) ? base_key_ff : fold;
      gnonce_in = iv_ff + {68'b0, sha_ctl.pos[63:4]};
      cnonce_in = iv_ff + {68'b0, ctr_pos[63:4]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= sha_ctl.valid & ~sha_ctl.base;
      end
      gkey_ff   <= gkey_in;
      gnonce_ff <= gnonce_in;
      cnonce_ff <= cnonce_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_gmac_key_low    = gkey_ff[63:0];
   assign rsp_gmac_key_high   = gkey_ff[127:64];
   assign rsp_gmac_nonce_low  = gnonce_ff[63:0];
   assign rsp_gmac_nonce_high = gnonce_ff[127:64];
   assign rsp_ctr_nonce_low   = cnonce_ff[63:0];
   assign rsp_ctr_nonce_high  = cnonce_ff[127:64];

endmodule

### rtl/core/pknd_checker.sv
// Port-level checker for packet_key_nonce_derivation, bound to the top level.
// Depends on packet_key_nonce_derivation_defines.svh.
`include "packet_key_nonce_derivation_defines.svh"

module pknd_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic csr_valid,
   input logic csr_ready
);

   `PKND_ASSERT_NEXT_ALWAYS(a_busy_after_reset, clock, reset, busy, "busy low after reset")
   `PKND_ASSERT_NEXT_ALWAYS(a_busy_after_csr, clock, csr_valid && csr_ready, busy, "busy low after csr word")
   `PKND_ASSERT_NEXT(a_idle_holds, clock, reset, !busy && !csr_valid, !busy, "busy rose without csr word")

endmodule

bind packet_key_nonce_derivation pknd_checker u_pknd_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
